@@ design/mftr_pkg.sv @@
// Shared widths, reset values and register indexes for the mains fault trip relay.
`timescale 1ns / 1ps

package mftr_pkg;

  localparam int unsigned VoltW = 16;
  localparam int unsigned AmpW  = 17;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [VoltW-1:0] LowVoltReset  = VoltW'(2100);
  localparam logic [VoltW-1:0] HighVoltReset = VoltW'(2400);
  localparam logic [AmpW-1:0]  CurrentReset  = AmpW'(10000);
  localparam logic [TimeW-1:0] HoldReset     = TimeW'(600000);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOW_VOLT  = 2'd0,
    CFG_HIGH_VOLT = 2'd1,
    CFG_CURRENT   = 2'd2,
    CFG_HOLD      = 2'd3
  } cfg_idx_t;

endpackage

@@ design/mains_fault_trip_relay.sv @@
// Top level of the mains fault trip relay: sample register, fault logic, result register.
`timescale 1ns / 1ps

// Mains fault trip relay.
// Input channel (in_valid / in_stall) carries one mains sample a request:
// volts, amps, now_ms and test_on. Output channel (out_valid / out_stall)
// returns one result per sample: relay and buzzer state, three fault flags
// and four alert pulses.
// A sample is registered on acceptance and evaluated from the sample register
// into the result register once the output is free. One sample per cycle is
// sustained while out_stall stays low; the fault state updates once per
// sample in the evaluation cycle, which sets that figure.
// When out_stall is high with a result waiting, the result holds, the sample
// register holds its request, and in_stall rises once that register is full.
// Configuration writes (cfg_valid / cfg_ready) are always taken; cfg_ready is
// tied high. Reset loads the default limits, powers the relay, silences the
// buzzer, clears all fault flags and start times, and empties both registers.
module mains_fault_trip_relay (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mftr_pkg::VoltW-1:0]       volts,
  input  logic [mftr_pkg::AmpW-1:0]        amps,
  input  logic [mftr_pkg::TimeW-1:0]       now_ms,
  input  logic                             test_on,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             relay_on,
  output logic                             buzzer_on,
  output logic                             under_flag,
  output logic                             over_v_flag,
  output logic                             over_i_flag,
  output logic                             under_alert,
  output logic                             over_v_alert,
  output logic                             over_i_alert,
  output logic                             test_trip_alert,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mftr_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [mftr_pkg::CfgDataW-1:0]    cfg_data
);

  // configuration
  logic [mftr_pkg::VoltW-1:0] low_limit;
  logic [mftr_pkg::VoltW-1:0] high_limit;
  logic [mftr_pkg::AmpW-1:0]  cur_limit;
  logic [mftr_pkg::TimeW-1:0] hold_time;

  // sample register
  logic                       s1_valid;
  logic [mftr_pkg::VoltW-1:0] s1_volts;
  logic [mftr_pkg::AmpW-1:0]  s1_amps;
  logic [mftr_pkg::TimeW-1:0] s1_now;
  logic                       s1_test;

  // fault state
  logic                       under_act, over_v_act, over_i_act;
  logic [mftr_pkg::TimeW-1:0] under_since, over_v_since, over_i_since;
  logic                       relay, buzzer, was_testing;

  logic                       under_act_next, over_v_act_next, over_i_act_next;
  logic [mftr_pkg::TimeW-1:0] under_since_next, over_v_since_next, over_i_since_next;
  logic                       relay_next, buzzer_next;
  logic                       ua, ova, oia, ta;

  logic                       cond_u, cond_ov, cond_oi;
  logic                       b_under, b_over_v, b_over_i, b_relay, b_buzzer;
  logic [mftr_pkg::TimeW-1:0] b_under_since, b_over_v_since, b_over_i_since;

  logic out_free;
  logic advance;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign advance   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit  <= mftr_pkg::LowVoltReset;
      high_limit <= mftr_pkg::HighVoltReset;
      cur_limit  <= mftr_pkg::CurrentReset;
      hold_time  <= mftr_pkg::HoldReset;
    end else if (cfg_valid && cfg_ready) begin
      case (mftr_pkg::cfg_idx_t'(cfg_index))
        mftr_pkg::CFG_LOW_VOLT:  low_limit  <= cfg_data[mftr_pkg::VoltW-1:0];
        mftr_pkg::CFG_HIGH_VOLT: high_limit <= cfg_data[mftr_pkg::VoltW-1:0];
        mftr_pkg::CFG_CURRENT:   cur_limit  <= cfg_data[mftr_pkg::AmpW-1:0];
        mftr_pkg::CFG_HOLD:      hold_time  <= cfg_data[mftr_pkg::TimeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_volts <= volts;
      s1_amps  <= amps;
      s1_now   <= now_ms;
      s1_test  <= test_on;
    end
  end

  always_comb begin
    cond_u  = s1_volts < low_limit;
    cond_ov = s1_volts > high_limit;
    cond_oi = s1_amps > cur_limit;

    // entering test mode starts from a clean slate
    if (s1_test && !was_testing) begin
      b_under        = 1'b0;
      b_over_v       = 1'b0;
      b_over_i       = 1'b0;
      b_under_since  = '0;
      b_over_v_since = '0;
      b_over_i_since = '0;
      b_relay        = 1'b1;
      b_buzzer       = 1'b0;
    end else begin
      b_under        = under_act;
      b_over_v       = over_v_act;
      b_over_i       = over_i_act;
      b_under_since  = under_since;
      b_over_v_since = over_v_since;
      b_over_i_since = over_i_since;
      b_relay        = relay;
      b_buzzer       = buzzer;
    end

    under_act_next    = b_under;
    over_v_act_next   = b_over_v;
    over_i_act_next   = b_over_i;
    under_since_next  = b_under_since;
    over_v_since_next = b_over_v_since;
    over_i_since_next = b_over_i_since;
    relay_next        = b_relay;
    buzzer_next       = b_buzzer;
    ua  = 1'b0;
    ova = 1'b0;
    oia = 1'b0;
    ta  = 1'b0;

    if (s1_test) begin
      if (cond_u && !b_under) begin
        under_act_next = 1'b1;
        relay_next     = 1'b0;
        buzzer_next    = 1'b1;
        ta             = 1'b1;
      end else if (!cond_u && b_under) begin
        under_act_next = 1'b0;
        relay_next     = 1'b1;
        buzzer_next    = 1'b0;
      end
    end else begin
      // raise takes a start time, clear drops it to zero
      under_act_next   = cond_u;
      under_since_next = !cond_u ? '0 : (b_under ? b_under_since : s1_now);
      over_v_act_next   = cond_ov;
      over_v_since_next = !cond_ov ? '0 : (b_over_v ? b_over_v_since : s1_now);
      over_i_act_next   = cond_oi;
      over_i_since_next = !cond_oi ? '0 : (b_over_i ? b_over_i_since : s1_now);

      ua  = cond_u  && ((s1_now - under_since_next)  >= hold_time);
      ova = cond_ov && ((s1_now - over_v_since_next) >= hold_time);
      oia = cond_oi && ((s1_now - over_i_since_next) >= hold_time);
      if (ua || ova || oia) begin
        relay_next  = 1'b0;
        buzzer_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      under_act    <= 1'b0;
      over_v_act   <= 1'b0;
      over_i_act   <= 1'b0;
      under_since  <= '0;
      over_v_since <= '0;
      over_i_since <= '0;
      relay        <= 1'b1;
      buzzer       <= 1'b0;
      was_testing  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (advance) begin
        under_act    <= under_act_next;
        over_v_act   <= over_v_act_next;
        over_i_act   <= over_i_act_next;
        under_since  <= under_since_next;
        over_v_since <= over_v_since_next;
        over_i_since <= over_i_since_next;
        relay        <= relay_next;
        buzzer       <= buzzer_next;
        was_testing  <= s1_test;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      relay_on        <= relay_next;
      buzzer_on       <= buzzer_next;
      under_flag      <= under_act_next;
      over_v_flag     <= over_v_act_next;
      over_i_flag     <= over_i_act_next;
      under_alert     <= ua;
      over_v_alert    <= ova;
      over_i_alert    <= oia;
      test_trip_alert <= ta;
    end
  end

endmodule

@@ design/mftr_checker.sv @@
// Port checker for the mains fault trip relay, bound to the top level.
`timescale 1ns / 1ps

module mftr_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input logic relay_on,
  input logic buzzer_on,
  input logic under_flag,
  input logic over_v_flag,
  input logic over_i_flag,
  input logic under_alert,
  input logic over_v_alert,
  input logic over_i_alert,
  input logic test_trip_alert
);

  // relay and buzzer are always opposite
  a_relay_buzzer: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (relay_on != buzzer_on))
    else $error("relay and buzzer disagree");

  // any alert means the relay is open
  a_alert_trips: assert property (@(posedge clk) disable iff (rst)
    out_valid && (under_alert || over_v_alert || over_i_alert || test_trip_alert)
    |-> !relay_on)
    else $error("alert without trip");

  // a test trip excludes normal-mode alerts and needs the undervoltage flag
  a_test_trip: assert property (@(posedge clk) disable iff (rst)
    out_valid && test_trip_alert
    |-> under_flag && !under_alert && !over_v_alert && !over_i_alert)
    else $error("inconsistent test trip");

  // each hold-time alert needs its flag
  a_alert_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!under_alert || under_flag) && (!over_v_alert || over_v_flag)
                  && (!over_i_alert || over_i_flag))
    else $error("alert without its fault flag");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(relay_on) && $stable(under_flag))
    else $error("stalled result changed");

endmodule

bind mains_fault_trip_relay mftr_checker u_mftr_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .relay_on        (relay_on),
  .buzzer_on       (buzzer_on),
  .under_flag      (under_flag),
  .over_v_flag     (over_v_flag),
  .over_i_flag     (over_i_flag),
  .under_alert     (under_alert),
  .over_v_alert    (over_v_alert),
  .over_i_alert    (over_i_alert),
  .test_trip_alert (test_trip_alert)
);

@@ bench/mains_fault_trip_relay_test.sv @@
// Self-checking testbench for the mains fault trip relay: predicted results vs. RTL output.
`timescale 1ns / 1ps

module mains_fault_trip_relay_test;
  import mftr_pkg::*;

  typedef struct packed {
    logic relay_on;
    logic buzzer_on;
    logic under_flag;
    logic over_v_flag;
    logic over_i_flag;
    logic under_alert;
    logic over_v_alert;
    logic over_i_alert;
    logic test_trip_alert;
  } relay_result_t;

  typedef enum {LEVEL_UNDER, LEVEL_NORMAL, LEVEL_OVER, LEVEL_ANY} level_t;

  // Fault indexes into the predictor's per-fault state.
  localparam int FaultUnder = 0;
  localparam int FaultOverV = 1;
  localparam int FaultOverI = 2;

  class relay_scoreboard;
    logic [VoltW-1:0] low_lim, high_lim;
    logic [AmpW-1:0]  cur_lim;
    logic [TimeW-1:0] hold_ms;
    logic             fault_on [3];
    logic [TimeW-1:0] fault_since [3];
    logic             relay_st, buzzer_st, in_test;
    relay_result_t    expected_q [$];
    int               errors;
    string            field_name [9] = '{"test_trip_alert", "over_i_alert", "over_v_alert",
                                         "under_alert", "over_i_flag", "over_v_flag",
                                         "under_flag", "buzzer_on", "relay_on"};

    function new();
      low_lim  = LowVoltReset;
      high_lim = HighVoltReset;
      cur_lim  = CurrentReset;
      hold_ms  = HoldReset;
      clear_trip();
      in_test = 1'b0;
      errors  = 0;
    endfunction

    function void clear_trip();
      for (int i = 0; i < 3; i++) begin
        fault_on[i]    = 1'b0;
        fault_since[i] = '0;
      end
      relay_st  = 1'b1;
      buzzer_st = 1'b0;
    endfunction

    function void set_limit(cfg_idx_t idx, logic [CfgDataW-1:0] word);
      case (idx)
        CFG_LOW_VOLT:  low_lim  = word[VoltW-1:0];
        CFG_HIGH_VOLT: high_lim = word[VoltW-1:0];
        CFG_CURRENT:   cur_lim  = word[AmpW-1:0];
        CFG_HOLD:      hold_ms  = word[TimeW-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_sample(logic [VoltW-1:0] v, logic [AmpW-1:0] a,
                              logic [TimeW-1:0] t, logic tst);
      logic             cond [3];
      logic             alert [3];
      logic             test_alert;
      logic [TimeW-1:0] elapsed;
      relay_result_t    r;
      cond[FaultUnder] = v < low_lim;
      cond[FaultOverV] = v > high_lim;
      cond[FaultOverI] = a > cur_lim;
      for (int i = 0; i < 3; i++) alert[i] = 1'b0;
      test_alert = 1'b0;
      if (tst && !in_test) clear_trip();
      in_test = tst;
      if (tst) begin
        // test mode: undervoltage trips at once, any voltage not under the low limit restores
        if (cond[FaultUnder]) begin
          if (!fault_on[FaultUnder]) begin
            fault_on[FaultUnder] = 1'b1;
            relay_st   = 1'b0;
            buzzer_st  = 1'b1;
            test_alert = 1'b1;
          end
        end else if (fault_on[FaultUnder]) begin
          fault_on[FaultUnder] = 1'b0;
          relay_st  = 1'b1;
          buzzer_st = 1'b0;
        end
      end else begin
        for (int i = 0; i < 3; i++) begin
          if (cond[i]) begin
            if (!fault_on[i]) begin
              fault_on[i]    = 1'b1;
              fault_since[i] = t;
            end
          end else if (fault_on[i]) begin
            fault_on[i]    = 1'b0;
            fault_since[i] = '0;
          end
          elapsed  = t - fault_since[i];
          alert[i] = fault_on[i] && (elapsed >= hold_ms);
        end
        if (alert[FaultUnder] || alert[FaultOverV] || alert[FaultOverI]) begin
          relay_st  = 1'b0;
          buzzer_st = 1'b1;
        end
      end
      r.relay_on        = relay_st;
      r.buzzer_on       = buzzer_st;
      r.under_flag      = fault_on[FaultUnder];
      r.over_v_flag     = fault_on[FaultOverV];
      r.over_i_flag     = fault_on[FaultOverI];
      r.under_alert     = alert[FaultUnder];
      r.over_v_alert    = alert[FaultOverV];
      r.over_i_alert    = alert[FaultOverI];
      r.test_trip_alert = test_alert;
      expected_q.push_back(r);
    endfunction

    function void check_result(relay_result_t got);
      relay_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %b", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      for (int i = 0; i < 9; i++) begin
        if (want[i] !== got[i]) begin
          $display("%0t: %s mismatch, expected %0b, actual %0b",
                   $time, field_name[i], want[i], got[i]);
          errors++;
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [VoltW-1:0]    volts = '0;
  logic [AmpW-1:0]     amps = '0;
  logic [TimeW-1:0]    now_ms = '0;
  logic                test_on = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                relay_on, buzzer_on, under_flag, over_v_flag, over_i_flag;
  logic                under_alert, over_v_alert, over_i_alert, test_trip_alert;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = CFG_LOW_VOLT;
  logic [CfgDataW-1:0] cfg_data = '0;

  relay_scoreboard sb = new();

  mains_fault_trip_relay u_top (.*);

  always #2 clk = ~clk;

  // Receiver: stall percentage is redrawn at random from 0, 20, 50 and 85, zero included.
  int stall_pct = 0;
  int stall_age = 0;
  always @(negedge clk) begin
    if (stall_age == 0) begin
      case ($urandom_range(3, 0))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
      stall_age = $urandom_range(80, 10);
    end else begin
      stall_age--;
    end
    out_stall <= ($urandom_range(99, 0) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result('{relay_on, buzzer_on, under_flag, over_v_flag, over_i_flag,
                        under_alert, over_v_alert, over_i_alert, test_trip_alert});
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic send_sample(logic [VoltW-1:0] v, logic [AmpW-1:0] a,
                             logic [TimeW-1:0] t, logic tst);
    @(negedge clk);
    in_valid <= 1'b1;
    volts    <= v;
    amps     <= a;
    now_ms   <= t;
    test_on  <= tst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(v, a, t, tst);
  endtask

  task automatic idle_in(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Hold off new requests until every expected result is back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] word);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_limit(idx, word);
  endtask

  // Upper bits of the narrow registers carry junk; the block must mask them.
  task automatic load_setting(logic [VoltW-1:0] lo, logic [VoltW-1:0] hi,
                              logic [AmpW-1:0] cur, logic [TimeW-1:0] hold);
    logic [CfgDataW-1:0] word;
    word = $urandom;
    word[VoltW-1:0] = lo;
    write_reg(CFG_LOW_VOLT, word);
    word = $urandom;
    word[VoltW-1:0] = hi;
    write_reg(CFG_HIGH_VOLT, word);
    word = $urandom;
    word[AmpW-1:0] = cur;
    write_reg(CFG_CURRENT, word);
    write_reg(CFG_HOLD, hold);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [VoltW-1:0] pick_volts(level_t k);
    case (k)
      LEVEL_UNDER:
        return (sb.low_lim == 0) ? '0 : VoltW'($urandom_range(sb.low_lim - 1, 0));
      LEVEL_NORMAL:
        return (sb.low_lim <= sb.high_lim) ?
               VoltW'($urandom_range(sb.high_lim, sb.low_lim)) : VoltW'($urandom);
      LEVEL_OVER:
        return (sb.high_lim == '1) ? '1 : VoltW'($urandom_range(16'hFFFF, sb.high_lim + 1));
      default:
        return VoltW'($urandom);
    endcase
  endfunction

  function automatic logic [AmpW-1:0] pick_amps(level_t k);
    case (k)
      LEVEL_UNDER, LEVEL_NORMAL:
        return AmpW'($urandom_range(sb.cur_lim, 0));
      LEVEL_OVER:
        return (sb.cur_lim == '1) ? '1 : AmpW'($urandom_range(17'h1FFFF, sb.cur_lim + 1));
      default:
        return AmpW'($urandom);
    endcase
  endfunction

  // Timestamp advance: half the time up to a quarter of the hold time, else zero, boundary, random and wrap jumps.
  function automatic logic [TimeW-1:0] next_step();
    case ($urandom_range(9, 0))
      0: return '0;
      1: return sb.hold_ms;
      2: return sb.hold_ms - 1;
      3: return $urandom;
      4: return '1;
      default: return $urandom_range((sb.hold_ms >> 2) + 1, 0);
    endcase
  endfunction

  initial begin
    logic [TimeW-1:0] clock_ms;
    logic [VoltW-1:0] lo, hi;
    logic [AmpW-1:0]  cur;
    logic [TimeW-1:0] hold;
    level_t           v_kind, a_kind;
    int               v_left, a_left, t_left, burst_left;
    logic             testing, gappy;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset limits: hold-time trip, latch, test mode, carry-over and wrap.
    send_sample(16'd2300, 17'd5000, 32'd1000, 1'b0);
    send_sample(16'd2000, 17'd5000, 32'd2000, 1'b0);
    send_sample(16'd2000, 17'd5000, 32'd602000, 1'b0);
    send_sample(16'd2300, 17'd5000, 32'd602001, 1'b0);
    send_sample(16'd2300, 17'd5000, 32'd602002, 1'b1);
    send_sample(16'd1000, 17'd0, 32'd602003, 1'b1);
    send_sample(16'd1000, 17'd0, 32'd602004, 1'b1);
    send_sample(16'd2300, 17'd0, 32'd602005, 1'b1);
    send_sample(16'd1000, 17'd0, 32'd602006, 1'b1);
    send_sample(16'd1000, 17'd0, 32'd700000, 1'b0);
    send_sample(16'd2300, 17'd0, 32'd0, 1'b1);
    send_sample(16'd2500, 17'h1FFFF, 32'd5, 1'b1);
    send_sample(16'd2500, 17'h1FFFF, 32'hFFFF_FFF0, 1'b0);
    send_sample(16'd2500, 17'h1FFFF, 32'd599984, 1'b0);
    send_sample(16'hFFFF, 17'h1FFFF, 32'hFFFF_FFFF, 1'b0);
    send_sample(16'd0, 17'd0, 32'd0, 1'b0);
    drain_results();

    // Zero hold with every fault as easy to raise as it gets.
    load_setting(16'hFFFF, 16'd0, 17'd0, 32'd0);
    send_sample(16'hFFFF, 17'd0, 32'd50, 1'b1);
    send_sample(16'd100, 17'd1, 32'd51, 1'b0);
    send_sample(16'hFFFF, 17'd0, 32'd52, 1'b0);
    send_sample(16'd0, 17'h1FFFF, 32'd53, 1'b1);
    drain_results();

    clock_ms = $urandom;
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin lo = LowVoltReset; hi = HighVoltReset; cur = CurrentReset; hold = HoldReset; end
        1: begin lo = 16'd2100; hi = 16'd2400; cur = 17'd10000; hold = '0; end
        2: begin lo = '0; hi = '1; cur = '1; hold = '1; end
        3: begin lo = '1; hi = '0; cur = '0; hold = 32'd3; end
        4: begin lo = 16'd1; hi = 16'hFFFE; cur = 17'h1FFFE; hold = 32'd40; end
        default: begin
          lo   = VoltW'($urandom_range(60000, 0));
          hi   = VoltW'($urandom_range(16'hFFFF, lo));
          cur  = AmpW'($urandom);
          hold = ($urandom_range(2, 0) == 0) ? $urandom : $urandom_range(100000, 1);
        end
      endcase
      load_setting(lo, hi, cur, hold);
      gappy = ($urandom_range(2, 0) != 0);
      v_left = 0;
      a_left = 0;
      t_left = 0;
      burst_left = $urandom_range(20, 1);
      for (int n = 0; n < 188; n++) begin
        if (v_left == 0) begin
          v_kind = level_t'($urandom_range(3, 0));
          v_left = $urandom_range(15, 1);
        end
        if (a_left == 0) begin
          a_kind = level_t'($urandom_range(3, 0));
          a_left = $urandom_range(15, 1);
        end
        if (t_left == 0) begin
          testing = ($urandom_range(11, 0) == 0);
          t_left  = testing ? $urandom_range(6, 1) : $urandom_range(25, 3);
        end
        v_left--;
        a_left--;
        t_left--;
        clock_ms += next_step();
        send_sample(pick_volts(v_kind), pick_amps(a_kind), clock_ms, testing);
        if (p == 6 && n == 90) drain_results();
        burst_left--;
        if (burst_left == 0) begin
          if (gappy) idle_in($urandom_range(6, 1));
          burst_left = $urandom_range(20, 1);
        end
      end
      drain_results();
    end

    repeat (6) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
